[design/ble_pkg.sv]
// Shared constants, types and opcodes for the bounded list engine.
package ble_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_CLEAR       = 3'd1,
    OP_SWAP_REMOVE = 3'd2,
    OP_STABLE_REM  = 3'd3,
    OP_FIND_FIRST  = 3'd4,
    OP_FIND_LAST   = 3'd5
  } op_t;

endpackage

[design/ble_chan_if.sv]
// Valid/ready channel interfaces for the input, result and configuration ports.
interface ble_in_if;
  import ble_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] operand_value;
  logic [ADDR_W-1:0]        target_position;
  modport source (output valid, output opcode, output operand_value,
                  output target_position, input ready);
  modport sink   (input valid, input opcode, input operand_value,
                  input target_position, output ready);
endinterface

interface ble_out_if;
  import ble_pkg::*;
  logic              valid;
  logic              ready;
  logic              success;
  logic [ADDR_W-1:0] found_position;
  logic [CNT_W-1:0]  current_length;
  modport source (output valid, output success, output found_position,
                  output current_length, input ready);
  modport sink   (input valid, input success, input found_position,
                  input current_length, output ready);
endinterface

interface ble_cfg_if;
  import ble_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capacity_limit;
  modport source (output valid, output capacity_limit, input ready);
  modport sink   (input valid, input capacity_limit, output ready);
endinterface

[design/ble_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/bounded_list_engine_top.sv]
// Bounded list engine: list of signed words in one RAM with append, clear, remove, search.
// Usage:
//   in_if  : one item per handshake (opcode, operand_value, target_position).
//   out_if : exactly one result item per input item (success, found_position,
//            current_length), in input order.
//   cfg_if : writes capacity_limit; always ready; write only while idle.
// Sequence (accept to result valid):
//   append, clear, failed remove, unused opcode : S_DONE, then the output register
//   swap remove   : S_SWAP, S_DONE, then the output register
//   stable remove : S_SHIFT moves each entry above the target down one place, S_DONE, output register
//   find first    : S_FWD walks forward from entry 0, stops at the first match
//   find last     : S_BWD walks backward from the last entry, stops at the last match
//   The walks go through the single read port of the store: one entry per cycle.
//   One item is worked on at a time; the next item is taken once the previous
//   result sits in the output register, even while that result still waits.
// Reset: length clears to zero and capacity_limit returns to 256; the store
//   itself is not cleared, entries at or above the length are never used.
// Stall: a held result keeps its value; a finished item waits in the done
//   state until the output register frees up.
module bounded_list_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  ble_in_if.sink      in_if,
  ble_out_if.source   out_if,
  ble_cfg_if.sink     cfg_if
);
  import ble_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWAP,
    S_SHIFT,
    S_FWD,
    S_BWD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   fill_r, fill_nxt;
  cnt_t   cap_r;
  cnt_t   idx_r, idx_nxt;
  word_t  word_r, word_nxt;
  logic   ok_r, ok_nxt;
  addr_t  pos_r, pos_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_success_r;
  addr_t  out_pos_r;
  cnt_t   out_len_r;

  logic   ram_we;
  addr_t  ram_waddr;
  word_t  ram_wdata;
  addr_t  ram_raddr;
  word_t  ram_rdata;

  logic   in_accept;
  logic   out_free;
  logic   load_out;
  cnt_t   idx_inc;
  cnt_t   fill_dec;
  cnt_t   target_ext;

  ble_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_accept    = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;
  assign load_out     = (state_r == S_DONE) && out_free;
  assign idx_inc      = idx_r + cnt_t'(1);
  assign fill_dec     = fill_r - cnt_t'(1);
  assign target_ext   = cnt_t'(in_if.target_position);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid          = out_valid_r;
  assign out_if.success        = out_success_r;
  assign out_if.found_position = out_pos_r;
  assign out_if.current_length = out_len_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    word_nxt  = word_r;
    ok_nxt    = ok_r;
    pos_nxt   = pos_r;
    ram_we    = 1'b0;
    ram_waddr = fill_r[ADDR_W-1:0];
    ram_wdata = in_if.operand_value;
    ram_raddr = idx_inc[ADDR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          ok_nxt    = 1'b0;
          pos_nxt   = '0;
          word_nxt  = in_if.operand_value;
          state_nxt = S_DONE;
          case (op_t'(in_if.opcode))
            OP_APPEND: begin
              if (fill_r < cap_r && fill_r < cnt_t'(DEPTH)) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + cnt_t'(1);
                ok_nxt   = 1'b1;
              end
            end
            OP_CLEAR: begin
              fill_nxt = '0;
              ok_nxt   = 1'b1;
            end
            OP_SWAP_REMOVE: begin
              if (target_ext < fill_r) begin
                ram_raddr = fill_dec[ADDR_W-1:0];
                idx_nxt   = target_ext;
                state_nxt = S_SWAP;
              end
            end
            OP_STABLE_REM: begin
              if (target_ext < fill_r) begin
                ram_raddr = in_if.target_position + addr_t'(1);
                idx_nxt   = target_ext;
                state_nxt = S_SHIFT;
              end
            end
            OP_FIND_FIRST: begin
              if (fill_r != '0) begin
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_FWD;
              end
            end
            OP_FIND_LAST: begin
              if (fill_r != '0) begin
                ram_raddr = fill_dec[ADDR_W-1:0];
                idx_nxt   = fill_dec;
                state_nxt = S_BWD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        fill_nxt  = fill_dec;
        ok_nxt    = 1'b1;
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        if (idx_inc < fill_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r[ADDR_W-1:0];
          ram_wdata = ram_rdata;
          ram_raddr = idx_r[ADDR_W-1:0] + addr_t'(2);
          idx_nxt   = idx_inc;
        end else begin
          fill_nxt  = fill_dec;
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FWD: begin
        if (ram_rdata == word_r) begin
          ok_nxt    = 1'b1;
          pos_nxt   = idx_r[ADDR_W-1:0];
          state_nxt = S_DONE;
        end else if (idx_inc < fill_r) begin
          ram_raddr = idx_inc[ADDR_W-1:0];
          idx_nxt   = idx_inc;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BWD: begin
        if (ram_rdata == word_r) begin
          ok_nxt    = 1'b1;
          pos_nxt   = idx_r[ADDR_W-1:0];
          state_nxt = S_DONE;
        end else if (idx_r != '0) begin
          ram_raddr = idx_r[ADDR_W-1:0] - addr_t'(1);
          idx_nxt   = idx_r - cnt_t'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= cnt_t'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        cap_r <= cfg_if.capacity_limit;
      end
    end
    idx_r  <= idx_nxt;
    word_r <= word_nxt;
    ok_r   <= ok_nxt;
    pos_r  <= pos_nxt;
    if (load_out) begin
      out_success_r <= ok_r;
      out_pos_r     <= pos_r;
      out_len_r     <= fill_r;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cnt_t'(DEPTH))
    else $error("list length exceeds store depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP || state_r == S_SHIFT || state_r == S_FWD || state_r == S_BWD)
      |-> (idx_r < fill_r))
    else $error("walk index outside the held entries");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_if.opcode == OP_APPEND && fill_r < cap_r && fill_r < cnt_t'(DEPTH))
      |=> (fill_r == $past(fill_r) + cnt_t'(1)))
    else $error("accepted append did not grow the list");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_SWAP || state_r == S_SHIFT))
    else $error("store written outside append or remove");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("item accepted without producing a result");

endmodule
